// ===== src/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/fpba_pkg.sv =====
// Shared types and constants of the fit-policy block allocator.
// No dependencies; used by the APB registers, controller, datapath and top level.
package fpba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 128;
  localparam int unsigned SIZE_W         = 16;
  localparam int unsigned IDX_W          = 7;
  localparam int unsigned CMD_W          = 1;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned COUNT_W        = 8;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned PADDR_W        = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  // Register select taken from paddr[2]
  typedef enum logic {
    REG_FIT_MODE    = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } reg_sel_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  entry_index;
    logic [SIZE_W-1:0] size_value;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  chosen_index;
    logic [SIZE_W-1:0] original_size;
    logic [SIZE_W-1:0] remaining_size;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic wb;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic limit_zero;
    logic last_issue;
    logic found;
    logic out_full;
  } dp_sts_t;

endpackage

// ===== src/fpba_chan_if.sv =====
// Valid/ready channel carrying one payload struct.
// Payload type comes in as a parameter, normally a struct from fpba_pkg.
interface fpba_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/fpba_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module fpba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fpba_apb_regs.sv =====
// APB configuration registers: placement policy and searched block count.
// Depends on fpba_pkg.
module fpba_apb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fpba_pkg::PADDR_W-1:0]        paddr,
  input  logic [fpba_pkg::DATA_W-1:0]         pwdata,
  output logic [fpba_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  output logic [fpba_pkg::MODE_W-1:0]         fit_mode_o,
  output logic [fpba_pkg::COUNT_W-1:0]        block_count_o
);

  logic [fpba_pkg::MODE_W-1:0]  fit_mode_q, fit_mode_d;
  logic [fpba_pkg::COUNT_W-1:0] block_count_q, block_count_d;
  fpba_pkg::reg_sel_e           sel;
  logic                         wr_en;

  // Low address bits are the byte offset within a word
  assign sel    = fpba_pkg::reg_sel_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    fit_mode_d    = fit_mode_q;
    block_count_d = block_count_q;
    if (wr_en) begin
      unique case (sel)
        fpba_pkg::REG_FIT_MODE:    fit_mode_d    = pwdata[fpba_pkg::MODE_W-1:0];
        fpba_pkg::REG_BLOCK_COUNT: block_count_d = pwdata[fpba_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      fpba_pkg::REG_FIT_MODE:    prdata = fpba_pkg::DATA_W'(fit_mode_q);
      fpba_pkg::REG_BLOCK_COUNT: prdata = fpba_pkg::DATA_W'(block_count_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= fpba_pkg::FIT_FIRST;
      block_count_q <= fpba_pkg::COUNT_W'(1);
    end else begin
      fit_mode_q    <= fit_mode_d;
      block_count_q <= block_count_d;
    end
  end

  assign fit_mode_o    = fit_mode_q;
  assign block_count_o = block_count_q;

endmodule

// ===== src/fpba_ctrl.sv =====
// Controller state machine: accept, table scan, write-back, result transfer.
// Depends on fpba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  fpba_pkg::dp_sts_t sts_i,
  output fpba_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_LAST = 5'b00100,
    ST_WB   = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    req_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (sts_i.is_load || sts_i.limit_zero) ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.last_issue) begin
          state_d = ST_LAST;
        end
      end
      // last read data is compared in this cycle
      ST_LAST: state_d = ST_WB;
      ST_WB: begin
        cmd_o.wb = sts_i.found;
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_PROP(a_one_item_at_a_time, clk_i, rst_ni, cmd_o.accept |=> !req_ready_o, "item accepted while busy")

endmodule

// ===== src/fpba_dp.sv =====
// Datapath: request hold, scan counter, best-candidate tracking, output register.
// Depends on fpba_pkg and assert_macros.svh; drives the table RAM port.
`include "assert_macros.svh"

module fpba_dp #(
  parameter int unsigned MaxBlocks = fpba_pkg::MAX_BLOCKS_DEF,
  localparam int unsigned AddrW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1,
  localparam int unsigned CntW  = ($clog2(MaxBlocks + 1) > fpba_pkg::COUNT_W) ?
                                  $clog2(MaxBlocks + 1) : fpba_pkg::COUNT_W,
  localparam int unsigned RamW  = 2 * fpba_pkg::SIZE_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fpba_pkg::dp_cmd_t             cmd_i,
  output fpba_pkg::dp_sts_t             sts_o,
  input  fpba_pkg::req_t                req_payload_i,
  input  logic [fpba_pkg::MODE_W-1:0]   fit_mode_i,
  input  logic [fpba_pkg::COUNT_W-1:0]  block_count_i,
  output fpba_pkg::rsp_t                rsp_payload_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic                          ram_we_o,
  output logic [AddrW-1:0]              ram_addr_o,
  output logic [RamW-1:0]               ram_wdata_o,
  input  logic [RamW-1:0]               ram_rdata_i
);

  localparam int unsigned SW = fpba_pkg::SIZE_W;

  fpba_pkg::req_t   req_q;
  fpba_pkg::rsp_t   out_q, rsp_d;
  logic [CntW-1:0]  limit_d, limit_q, cnt_q, count_ext;
  logic [AddrW-1:0] rd_idx_q, best_idx_q;
  logic [SW-1:0]    best_free_q, best_orig_q, rd_free, rd_orig, new_free;
  logic             rd_vld_q, found_q, out_vld_q;
  logic             fits, take, in_range_in, in_range_q;

  assign count_ext = CntW'(block_count_i);
  assign limit_d   = (count_ext > CntW'(MaxBlocks)) ? CntW'(MaxBlocks) : count_ext;

  assign in_range_in = (32'(req_payload_i.entry_index) < MaxBlocks);
  assign in_range_q  = (32'(req_q.entry_index) < MaxBlocks);

  assign rd_orig  = ram_rdata_i[RamW-1:SW];
  assign rd_free  = ram_rdata_i[SW-1:0];
  assign new_free = best_free_q - req_q.size_value;

  // Ties keep the earlier, lower index
  always_comb begin
    fits = (rd_free >= req_q.size_value);
    take = 1'b0;
    if (rd_vld_q && fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else begin
        unique case (fit_mode_i)
          fpba_pkg::FIT_BEST:  take = (rd_free < best_free_q);
          fpba_pkg::FIT_WORST: take = (rd_free > best_free_q);
          default:             take = 1'b0;
        endcase
      end
    end
  end

  // Table port: load write at accept, scan read, then write-back of the pick
  always_comb begin
    ram_we_o    = 1'b0;
    ram_addr_o  = cnt_q[AddrW-1:0];
    ram_wdata_o = {best_orig_q, new_free};
    if (cmd_i.accept) begin
      ram_we_o    = (req_payload_i.command == fpba_pkg::CMD_LOAD) && in_range_in;
      ram_addr_o  = AddrW'(req_payload_i.entry_index);
      ram_wdata_o = {req_payload_i.size_value, req_payload_i.size_value};
    end else if (cmd_i.wb) begin
      ram_we_o   = 1'b1;
      ram_addr_o = best_idx_q;
    end
  end

  always_comb begin
    rsp_d = '0;
    if (req_q.command == fpba_pkg::CMD_LOAD) begin
      rsp_d.chosen_index = req_q.entry_index;
      if (in_range_q) begin
        rsp_d.original_size  = req_q.size_value;
        rsp_d.remaining_size = req_q.size_value;
      end
    end else if (found_q) begin
      rsp_d.granted        = 1'b1;
      rsp_d.chosen_index   = fpba_pkg::IDX_W'(best_idx_q);
      rsp_d.original_size  = best_orig_q;
      rsp_d.remaining_size = new_free;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.accept) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= req_payload_i;
      limit_q <= limit_d;
      cnt_q   <= '0;
    end else if (cmd_i.scan_rd) begin
      cnt_q <= cnt_q + CntW'(1);
    end
    rd_idx_q <= cnt_q[AddrW-1:0];
    if (take) begin
      best_idx_q  <= rd_idx_q;
      best_free_q <= rd_free;
      best_orig_q <= rd_orig;
    end
    if (cmd_i.out_load) begin
      out_q <= rsp_d;
    end
  end

  assign sts_o.is_load    = (req_payload_i.command == fpba_pkg::CMD_LOAD);
  assign sts_o.limit_zero = (block_count_i == '0);
  assign sts_o.last_issue = (cnt_q == (limit_q - CntW'(1)));
  assign sts_o.found      = found_q;
  assign sts_o.out_full   = out_vld_q && !rsp_ready_i;

  assign rsp_valid_o   = out_vld_q;
  assign rsp_payload_o = out_q;

  `ASSERT_PROP(a_wb_needs_pick, clk_i, rst_ni, cmd_i.wb |-> found_q, "write-back without a chosen block")
  `ASSERT_NEVER(a_no_write_in_scan, clk_i, rst_ni, cmd_i.scan_rd && ram_we_o, "table written during scan")

endmodule

// ===== src/fit_policy_block_allocator_unit.sv =====
// Load: the accept is followed by the result register. Allocate, with N = block_count
// capped at MaxBlocks (handled like a load when N is 0): N table reads, one read per cycle from
// the single-port RAM, then a compare of the last read and a write-back of the pick when one fits.
// One item in work at a time; the result is registered once the output register is free,
// and the next transfer is taken the cycle after. Reset clears control and config
// (fit_mode 0, block_count 1); table contents are undefined until loaded.
module fit_policy_block_allocator_unit #(
  parameter int unsigned MaxBlocks = fpba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fpba_chan_if.sink                    req_i,
  fpba_chan_if.source                  rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fpba_pkg::PADDR_W-1:0] paddr,
  input  logic [fpba_pkg::DATA_W-1:0]  pwdata,
  output logic [fpba_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned AddrW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned RamW  = 2 * fpba_pkg::SIZE_W;

  fpba_pkg::dp_cmd_t             dp_cmd;
  fpba_pkg::dp_sts_t             dp_sts;
  fpba_pkg::rsp_t                rsp_payload;
  logic [fpba_pkg::MODE_W-1:0]   fit_mode;
  logic [fpba_pkg::COUNT_W-1:0]  block_count;
  logic                          req_ready, rsp_valid, ram_we;
  logic [AddrW-1:0]              ram_addr;
  logic [RamW-1:0]               ram_wdata, ram_rdata;

  fpba_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fit_mode_o   (fit_mode),
    .block_count_o(block_count)
  );

  fpba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  fpba_dp #(
    .MaxBlocks(MaxBlocks)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .req_payload_i(req_i.payload),
    .fit_mode_i   (fit_mode),
    .block_count_i(block_count),
    .rsp_payload_o(rsp_payload),
    .rsp_valid_o  (rsp_valid),
    .rsp_ready_i  (rsp_o.ready),
    .ram_we_o     (ram_we),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata),
    .ram_rdata_i  (ram_rdata)
  );

  // Each word holds {original size, free size}
  fpba_ram #(
    .Width(RamW),
    .Depth(MaxBlocks)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign req_i.ready   = req_ready;
  assign rsp_o.valid   = rsp_valid;
  assign rsp_o.payload = rsp_payload;

endmodule

// ===== test/tb.sv =====
// Testbench for fit_policy_block_allocator_unit: directed and random table loads
// and allocations under every fit policy, checked against an in-bench predictor.
// Depends on fpba_pkg, fpba_chan_if and the allocator RTL.
module tb;
  import fpba_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 140;
  localparam int unsigned RAND_ITEMS  = 30;
  localparam int unsigned HOLD_AT     = 10;
  // unused policy code, behaves as first fit
  localparam logic [MODE_W-1:0] FIT_SPARE = 2'd3;

  typedef struct {
    req_t req;
    bit   hold_off;
  } pend_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  fpba_chan_if #(.payload_t(req_t)) req_if ();
  fpba_chan_if #(.payload_t(rsp_t)) rsp_if ();

  fit_policy_block_allocator_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Allocator state as predicted from accepted transfers
  logic [SIZE_W-1:0] free_left [MAX_BLOCKS_DEF];
  logic [SIZE_W-1:0] orig_size [MAX_BLOCKS_DEF];
  logic [MODE_W-1:0] cur_mode = FIT_FIRST;
  logic [COUNT_W-1:0] cur_count = COUNT_W'(1);
  bit loaded_map [MAX_BLOCKS_DEF];

  pend_item_t pending_q[$];
  rsp_t expected_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic rsp_t predict_allocation(req_t r);
    rsp_t o;
    int unsigned lim;
    int unsigned pick;
    bit hit;
    o = '0;
    pick = 0;
    hit = 1'b0;
    if (r.command == CMD_LOAD) begin
      free_left[r.entry_index] = r.size_value;
      orig_size[r.entry_index] = r.size_value;
      o.chosen_index = r.entry_index;
      o.original_size = r.size_value;
      o.remaining_size = r.size_value;
      return o;
    end
    lim = (cur_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : cur_count;
    for (int unsigned j = 0; j < lim; j++) begin
      if (free_left[j] < r.size_value) continue;
      if (!hit) begin
        hit = 1'b1;
        pick = j;
        if (cur_mode != FIT_BEST && cur_mode != FIT_WORST) break;
      end else if (cur_mode == FIT_BEST && free_left[j] < free_left[pick]) begin
        pick = j;
      end else if (cur_mode == FIT_WORST && free_left[j] > free_left[pick]) begin
        pick = j;
      end
    end
    if (hit) begin
      free_left[pick] = free_left[pick] - r.size_value;
      o.granted = 1'b1;
      o.chosen_index = pick[IDX_W-1:0];
      o.original_size = orig_size[pick];
      o.remaining_size = free_left[pick];
    end
    return o;
  endfunction

  task automatic check_field(string name, logic [SIZE_W-1:0] want, logic [SIZE_W-1:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: predict at each accepted transfer, then present the next pending item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_q.push_back(predict_allocation(req_if.payload));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_q[0].hold_off && expected_q.size() != 0)) begin
          req_if.valid <= 1'b1;
          req_if.payload <= pending_q[0].req;
          void'(pending_q.pop_front());
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, rsp_if.payload);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("granted", SIZE_W'(want.granted),
                      SIZE_W'(rsp_if.payload.granted));
          check_field("chosen_index", SIZE_W'(want.chosen_index),
                      SIZE_W'(rsp_if.payload.chosen_index));
          check_field("original_size", want.original_size, rsp_if.payload.original_size);
          check_field("remaining_size", want.remaining_size, rsp_if.payload.remaining_size);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(reg_sel_e sel, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] want;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_FIT_MODE) cur_mode = value[MODE_W-1:0];
    else cur_count = value[COUNT_W-1:0];
    want = (sel == REG_FIT_MODE) ? DATA_W'(cur_mode) : DATA_W'(cur_count);
    // read back through the same address
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== want) begin
      $display("%0t register %s readback: expected %0h, got %0h", $time, sel.name(), want,
               prdata);
      mismatches++;
    end
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || req_if.valid || expected_q.size() != 0);
  endtask

  task automatic start_phase(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count,
                             int unsigned idle_pct, int unsigned hold_pct);
    wait_drained();
    repeat (4) @(negedge clk_i);
    write_reg(REG_FIT_MODE, DATA_W'(mode));
    write_reg(REG_BLOCK_COUNT, DATA_W'(count));
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
  endtask

  task automatic push_item(cmd_e cmd, int unsigned idx, int unsigned size, bit hold);
    pend_item_t it;
    while (pending_q.size() >= 2) @(negedge clk_i);
    it.req.command = cmd;
    it.req.entry_index = idx[IDX_W-1:0];
    it.req.size_value = size[SIZE_W-1:0];
    it.hold_off = hold;
    if (cmd == CMD_LOAD) loaded_map[idx] = 1'b1;
    pending_q.push_back(it);
  endtask

  task automatic push_random(int unsigned lim, bit hold);
    int unsigned pick;
    int unsigned idx;
    int unsigned size;
    pick = $urandom_range(lim - 1);
    idx = $urandom_range(MAX_BLOCKS_DEF - 1);
    if ($urandom_range(99) < 35) begin
      if ($urandom_range(1) != 0) idx = $urandom_range(lim - 1);
      case ($urandom_range(4))
        0: size = $urandom_range(16'hFFFF);
        1: size = $urandom_range(31);
        2: size = free_left[pick];   // tie with a live entry
        3: size = 16'hFFFF;
        default: size = $urandom_range(4095);
      endcase
      push_item(CMD_LOAD, idx, size, hold);
    end else begin
      case ($urandom_range(5))
        0: size = free_left[pick];   // exact fit
        1: size = free_left[pick] + 1;
        2: size = (free_left[pick] > 8) ? free_left[pick] - $urandom_range(8) : 0;
        3: size = $urandom_range(15);
        4: size = $urandom_range(16'hFFFF);
        default: size = 0;
      endcase
      push_item(CMD_ALLOC, idx, size, hold);
    end
  endtask

  task automatic run_random_phase(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count,
                                  int unsigned idle_pct, int unsigned hold_pct);
    int unsigned lim;
    start_phase(mode, count, idle_pct, hold_pct);
    lim = (count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : count;
    // every searched entry must hold a size before any allocate reaches it
    for (int unsigned j = 0; j < lim; j++) begin
      if (!loaded_map[j]) push_item(CMD_LOAD, j, $urandom_range(16'hFFFF), 1'b0);
    end
    for (int unsigned k = 0; k < RAND_ITEMS; k++) push_random(lim, k == HOLD_AT);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first fit: extreme sizes, zero-size entry, zero request, no fit
    start_phase(FIT_FIRST, 8'd4, 0, 0);
    push_item(CMD_LOAD, 0, 16'hFFFF, 1'b0);
    push_item(CMD_LOAD, 1, 1, 1'b0);
    push_item(CMD_LOAD, 2, 0, 1'b0);
    push_item(CMD_LOAD, 3, 16'h8000, 1'b0);
    push_item(CMD_LOAD, MAX_BLOCKS_DEF - 1, 16'hAAAA, 1'b0);
    push_item(CMD_ALLOC, 0, 0, 1'b0);
    push_item(CMD_ALLOC, 127, 16'hFFFF, 1'b0);
    push_item(CMD_ALLOC, 0, 16'hFFFF, 1'b0);
    push_item(CMD_ALLOC, 0, 1, 1'b0);
    push_item(CMD_ALLOC, 0, 16'h4000, 1'b0);

    // best fit with equal sizes: lower index wins
    start_phase(FIT_BEST, 8'd4, 58, 0);
    push_item(CMD_LOAD, 0, 16'h0100, 1'b0);
    push_item(CMD_LOAD, 1, 16'h0010, 1'b0);
    push_item(CMD_LOAD, 2, 16'h0010, 1'b0);
    push_item(CMD_LOAD, 3, 16'h0020, 1'b0);
    push_item(CMD_ALLOC, 0, 8, 1'b0);
    push_item(CMD_ALLOC, 0, 8, 1'b0);
    push_item(CMD_ALLOC, 0, 16'h0020, 1'b0);
    push_item(CMD_ALLOC, 0, 16'h0200, 1'b0);

    // worst fit with a tie at the top, then a zero request
    start_phase(FIT_WORST, 8'd4, 0, 58);
    push_item(CMD_LOAD, 1, 16'h0100, 1'b0);
    push_item(CMD_ALLOC, 0, 16'h0010, 1'b0);
    push_item(CMD_ALLOC, 0, 0, 1'b0);

    // spare policy code with an empty search range
    start_phase(FIT_SPARE, 8'd0, 13, 13);
    push_item(CMD_ALLOC, 0, 1, 1'b0);
    push_item(CMD_ALLOC, 0, 0, 1'b0);

    run_random_phase(FIT_FIRST, 8'd1, 0, 0);
    run_random_phase(FIT_BEST, 8'd8, 58, 0);
    run_random_phase(FIT_WORST, 8'd16, 0, 58);
    run_random_phase(FIT_SPARE, 8'd6, 13, 13);
    run_random_phase(FIT_FIRST, 8'd128, 0, 0);
    run_random_phase(FIT_BEST, 8'd255, 58, 0);
    run_random_phase(FIT_WORST, 8'd128, 0, 58);
    run_random_phase(FIT_BEST, 8'd3, 13, 13);
    run_random_phase(FIT_FIRST, 8'd12, 58, 58);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== fit_policy_block_allocator_unit.f =====
+incdir+src
src/fpba_pkg.sv
src/fpba_chan_if.sv
src/fpba_ram.sv
src/fpba_apb_regs.sv
src/fpba_ctrl.sv
src/fpba_dp.sv
src/fit_policy_block_allocator_unit.sv
test/tb.sv
